/* design/mang_pkg.sv */
// Shared constants, types and saturation helpers for the multiband noise gate.
// Used by the gate core and its port checker; depends on nothing else.
package mang_pkg;

    // Sample and fixed-point formats.
    localparam int SAMPLE_BITS = 24;
    localparam int STATE_BITS  = 32;
    localparam int FRAC_BITS   = STATE_BITS - SAMPLE_BITS;
    localparam int COEF_BITS   = 16;
    localparam int GAIN_BITS   = COEF_BITS + 1;
    localparam int SCALE_BITS  = 12;
    localparam int SCALE_W     = 15;
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int BAND_COUNT  = 4;
    localparam int BAND_W      = 2;
    localparam int XOVER_COUNT = 3;

    localparam logic [GAIN_BITS-1:0] COEF_ONE  = GAIN_BITS'(1) << COEF_BITS;
    localparam logic [31:0]          LEVEL_EPS = 32'd2147;

    // State memory layout: twelve lowpass states, then envelopes, then floors.
    localparam int MEM_DEPTH = 20;
    localparam int ADDR_W    = 5;
    localparam logic [ADDR_W-1:0] ENV_BASE  = 5'd12;
    localparam logic [ADDR_W-1:0] FLR_BASE  = 5'd16;
    localparam logic [ADDR_W-1:0] CH_STRIDE = 5'd6;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_XOVER_COEFS = 3'd0,
        REG_ATTACK      = 3'd1,
        REG_RELEASE     = 3'd2,
        REG_LEARN_COEF  = 3'd3,
        REG_FLOOR_SCALE = 3'd4,
        REG_GATE_FLOOR  = 3'd5,
        REG_WET_MIX     = 3'd6,
        REG_LEARN_EN    = 3'd7
    } mang_reg_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LP_RD,
        ST_LP_DIFF,
        ST_LP_MUL,
        ST_LP_WR,
        ST_LP_B3,
        ST_B_MAG,
        ST_B_ENV_LD,
        ST_B_FLR_LD,
        ST_B_ENV_M2,
        ST_B_ENV_WR,
        ST_B_FLR_M2,
        ST_B_FLR_WR,
        ST_B_THR_MUL,
        ST_B_THR,
        ST_B_GATE_CHK,
        ST_B_DIV,
        ST_B_SQ,
        ST_B_SQ_WR,
        ST_B_GF_MUL,
        ST_B_GF,
        ST_B_L_MUL,
        ST_B_R_MUL,
        ST_B_R_ACC,
        ST_M_DL,
        ST_M_AL,
        ST_M_L,
        ST_M_AR,
        ST_M_R
    } mang_state_t;

    // Saturate a wide signed value to the 32-bit state range.
    function automatic logic signed [STATE_BITS-1:0] sat32(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sh07FFFFFFF;
        lo = -36'sh080000000;
        if (v > hi)
            return hi[STATE_BITS-1:0];
        else if (v < lo)
            return lo[STATE_BITS-1:0];
        else
            return v[STATE_BITS-1:0];
    endfunction

    // Saturate a 32-bit value to the signed sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [STATE_BITS-1:0] v);
        logic signed [STATE_BITS-1:0] hi;
        logic signed [STATE_BITS-1:0] lo;
        hi = STATE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo = -hi - STATE_BITS'(1);
        if (v > hi)
            return hi[SAMPLE_BITS-1:0];
        else if (v < lo)
            return lo[SAMPLE_BITS-1:0];
        else
            return v[SAMPLE_BITS-1:0];
    endfunction

    // Any gain above one acts as one.
    function automatic logic [GAIN_BITS-1:0] cap_one(input logic [GAIN_BITS-1:0] v);
        return (v > COEF_ONE) ? COEF_ONE : v;
    endfunction

endpackage

/* design/multiband_adaptive_noise_gate_core.sv */
// Channel   | Signals                               | Moves
// input     | in_valid, in_ready, left_in, right_in | one stereo word
// output    | out_valid, out_ready, left_out, ...   | one processed stereo word
// config    | cfg_write, cfg_index, cfg_data        | one register write, no wait
//
// From acceptance to result an item passes through the twelve lowpass
// sections and the top-band remainders, then each band, with the bit-serial
// divider only for a band whose gate needs it, and then the output mix. All
// products go through the single shared multiplier, and the divider gives
// one quotient bit per cycle.
// Reset clears the sequencer, the output flag and the state memory valid bits,
// so every filter, envelope and floor reads as zero until first written.
// A new word is taken in idle while a finished result may still wait in the
// output register; the last mix step holds while that register is occupied.
//
// Four-band adaptive noise gate core. Depends on mang_pkg.
module multiband_adaptive_noise_gate_core (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic signed [mang_pkg::SAMPLE_BITS-1:0]    left_in,
    input  logic signed [mang_pkg::SAMPLE_BITS-1:0]    right_in,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic signed [mang_pkg::SAMPLE_BITS-1:0]    left_out,
    output logic signed [mang_pkg::SAMPLE_BITS-1:0]    right_out,
    input  logic                                       cfg_write,
    input  logic [mang_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [mang_pkg::CFG_W-1:0]                 cfg_data
);
    import mang_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]      xo_coefs_reg;
    logic [COEF_BITS-1:0]  attack_reg;
    logic [COEF_BITS-1:0]  release_reg;
    logic [COEF_BITS-1:0]  learn_coef_reg;
    logic [SCALE_W-1:0]    floor_scale_reg;
    logic [GAIN_BITS-1:0]  gate_floor_reg;
    logic [GAIN_BITS-1:0]  wet_mix_reg;
    logic                  learn_en_reg;

    // Sequencer state and counters.
    mang_state_t           state_reg;
    mang_state_t           state_next;
    logic                  ch_reg;
    logic [1:0]            xo_reg;
    logic                  sec_reg;
    logic [BAND_W-1:0]     band_reg;
    logic [3:0]            cnt_reg;
    logic                  out_valid_reg;

    // Datapath registers.
    logic signed [STATE_BITS-1:0] rest_reg;
    logic signed [STATE_BITS-1:0] dry_l_reg;
    logic signed [STATE_BITS-1:0] dry_r_reg;
    logic signed [STATE_BITS-1:0] s_reg;
    logic signed [STATE_BITS:0]   diff_reg;
    logic signed [STATE_BITS-1:0] lp_reg;
    logic signed [STATE_BITS-1:0] hp_reg;
    logic signed [STATE_BITS-1:0] band_l_reg [BAND_COUNT];
    logic signed [STATE_BITS-1:0] band_r_reg [BAND_COUNT];
    logic [31:0]                  mag_reg;
    logic [31:0]                  env_old_reg;
    logic [31:0]                  flr_old_reg;
    logic [31:0]                  env_reg;
    logic [31:0]                  flr_reg;
    logic                         upd_reg;
    logic signed [MUL_P_W-1:0]    sum_reg;
    logic [34:0]                  thr_reg;
    logic [35:0]                  rem_reg;
    logic [COEF_BITS-1:0]         quo_reg;
    logic [GAIN_BITS-1:0]         gate_reg;
    logic signed [34:0]           acc_l_reg;
    logic signed [34:0]           acc_r_reg;
    logic signed [SAMPLE_BITS-1:0] res_l_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;

    // State memory and its read port.
    logic [STATE_BITS-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  mem_valid_reg;
    logic [STATE_BITS-1:0] rd_q_reg;
    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [STATE_BITS-1:0] mem_wdata;
    logic [STATE_BITS-1:0] rdata;

    // Shared multiplier.
    logic                         mul_en;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [MUL_P_W-1:0]    mul_reg;

    // Combinational helpers.
    logic                         in_accept;
    logic                         out_free;
    logic [ADDR_W-1:0]            lp_addr;
    logic [ADDR_W-1:0]            env_addr;
    logic [ADDR_W-1:0]            flr_addr;
    logic [COEF_BITS-1:0]         xo_coef;
    logic signed [STATE_BITS-1:0] lp_src;
    logic signed [STATE_BITS-1:0] lp_y;
    logic [COEF_BITS-1:0]         env_coef;
    logic [GAIN_BITS-1:0]         env_coef_inv;
    logic [GAIN_BITS-1:0]         learn_inv;
    logic signed [MUL_P_W-1:0]    smooth_sum;
    logic [31:0]                  smooth_new;
    logic [33:0]                  flr_x3;
    logic [33:0]                  mag_x2;
    logic [34:0]                  thr_raw;
    logic [35:0]                  rem_x2;
    logic                         rem_ge;
    logic                         gate_full;
    logic [GAIN_BITS-1:0]         gf_cap;
    logic [GAIN_BITS-1:0]         mix_cap;
    logic [GAIN_BITS-1:0]         gf_inv;
    logic [GAIN_BITS-1:0]         mix_inv;
    logic signed [STATE_BITS-1:0] abs_l;
    logic signed [STATE_BITS-1:0] abs_r;
    logic [32:0]                  abs_sum;
    logic signed [34:0]           gated_term;
    logic signed [MUL_P_W-1:0]    mix_sum;
    logic signed [SAMPLE_BITS-1:0] mix_out;
    logic signed [STATE_BITS-1:0] band3_val;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Configuration writes; unknown indexes cannot occur with a 3-bit index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xo_coefs_reg    <= '0;
            attack_reg      <= 16'd65000;
            release_reg     <= 16'd65400;
            learn_coef_reg  <= 16'd65534;
            floor_scale_reg <= 15'd12288;
            gate_floor_reg  <= 17'd13107;
            wet_mix_reg     <= 17'd65536;
            learn_en_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (mang_reg_t'(cfg_index))
                REG_XOVER_COEFS: xo_coefs_reg    <= cfg_data;
                REG_ATTACK:      attack_reg      <= cfg_data[COEF_BITS-1:0];
                REG_RELEASE:     release_reg     <= cfg_data[COEF_BITS-1:0];
                REG_LEARN_COEF:  learn_coef_reg  <= cfg_data[COEF_BITS-1:0];
                REG_FLOOR_SCALE: floor_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_GATE_FLOOR:  gate_floor_reg  <= cfg_data[GAIN_BITS-1:0];
                REG_WET_MIX:     wet_mix_reg     <= cfg_data[GAIN_BITS-1:0];
                REG_LEARN_EN:    learn_en_reg    <= cfg_data[0];
                default:         learn_en_reg    <= learn_en_reg;
            endcase
        end
    end

    // State memory: one write and one registered read per cycle. The sequence
    // never reads an entry in the cycle that writes it, so no forwarding.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_q_reg <= mem[mem_raddr];
    end

    // Valid bits stand in for clearing the memory at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mem_we)
                mem_valid_reg[mem_waddr] <= 1'b1;
            rd_valid_reg <= mem_valid_reg[mem_raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_q_reg : '0;

    // Shared multiplier with registered product.
    always_ff @(posedge clk)
    begin
        if (mul_en)
            mul_reg <= mul_a * mul_b;
    end

    // Addresses and coefficient selection.
    assign lp_addr  = (ch_reg ? CH_STRIDE : ADDR_W'(0)) + ADDR_W'({xo_reg, sec_reg});
    assign env_addr = ENV_BASE + ADDR_W'(band_reg);
    assign flr_addr = FLR_BASE + ADDR_W'(band_reg);

    always_comb
    begin
        case (xo_reg)
            2'd0:    xo_coef = xo_coefs_reg[15:0];
            2'd1:    xo_coef = xo_coefs_reg[31:16];
            2'd2:    xo_coef = xo_coefs_reg[47:32];
            default: xo_coef = '0;
        endcase
    end

    // Lowpass section arithmetic.
    assign lp_src = sec_reg ? lp_reg : rest_reg;
    assign lp_y   = sat32(36'(s_reg) + 36'(mul_reg >>> COEF_BITS));
    assign band3_val = sat32(36'(rest_reg) - 36'(ch_reg ? band_r_reg[XOVER_COUNT-1]
                                                        : band_l_reg[XOVER_COUNT-1]));

    // Envelope and floor smoothing.
    assign env_coef     = (mag_reg > env_old_reg) ? attack_reg : release_reg;
    assign env_coef_inv = COEF_ONE - {1'b0, env_coef};
    assign learn_inv    = COEF_ONE - {1'b0, learn_coef_reg};
    assign smooth_sum   = sum_reg + mul_reg;
    assign smooth_new   = smooth_sum[47:16];
    assign flr_x3       = {2'b00, flr_old_reg} + {1'b0, flr_old_reg, 1'b0};
    assign mag_x2       = {1'b0, mag_reg, 1'b0};

    // Band level is the mean absolute value of the two channels.
    assign abs_l   = band_l_reg[band_reg][STATE_BITS-1] ? -band_l_reg[band_reg]
                                                        : band_l_reg[band_reg];
    assign abs_r   = band_r_reg[band_reg][STATE_BITS-1] ? -band_r_reg[band_reg]
                                                        : band_r_reg[band_reg];
    assign abs_sum = {1'b0, abs_l} + {1'b0, abs_r};

    // Threshold, divider step and gate decision.
    assign thr_raw   = mul_reg[46:12];
    assign rem_x2    = {rem_reg[34:0], 1'b0};
    assign rem_ge    = rem_x2 >= {1'b0, thr_reg};
    assign gate_full = (env_reg <= LEVEL_EPS) || ({3'b000, env_reg} >= thr_reg);

    // Gains and output mix.
    assign gf_cap     = cap_one(gate_floor_reg);
    assign mix_cap    = cap_one(wet_mix_reg);
    assign gf_inv     = COEF_ONE - gf_cap;
    assign mix_inv    = COEF_ONE - mix_cap;
    assign gated_term = 35'(mul_reg >>> COEF_BITS);
    assign mix_sum    = sum_reg + mul_reg;
    assign mix_out    = sat_sample(STATE_BITS'(mix_sum >>> (COEF_BITS + FRAC_BITS)));

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (in_accept) state_next = ST_LP_RD;
            ST_LP_RD:      state_next = ST_LP_DIFF;
            ST_LP_DIFF:    state_next = ST_LP_MUL;
            ST_LP_MUL:     state_next = ST_LP_WR;
            ST_LP_WR:
            begin
                if (!sec_reg)
                    state_next = ST_LP_RD;
                else if (xo_reg == 2'(XOVER_COUNT - 1))
                    state_next = ST_LP_B3;
                else
                    state_next = ST_LP_RD;
            end
            ST_LP_B3:      state_next = ch_reg ? ST_B_MAG : ST_LP_RD;
            ST_B_MAG:      state_next = ST_B_ENV_LD;
            ST_B_ENV_LD:   state_next = ST_B_FLR_LD;
            ST_B_FLR_LD:   state_next = ST_B_ENV_M2;
            ST_B_ENV_M2:   state_next = ST_B_ENV_WR;
            ST_B_ENV_WR:   state_next = ST_B_FLR_M2;
            ST_B_FLR_M2:   state_next = ST_B_FLR_WR;
            ST_B_FLR_WR:   state_next = ST_B_THR_MUL;
            ST_B_THR_MUL:  state_next = ST_B_THR;
            ST_B_THR:      state_next = ST_B_GATE_CHK;
            ST_B_GATE_CHK: state_next = gate_full ? ST_B_GF_MUL : ST_B_DIV;
            ST_B_DIV:      if (cnt_reg == 4'hF) state_next = ST_B_SQ;
            ST_B_SQ:       state_next = ST_B_SQ_WR;
            ST_B_SQ_WR:    state_next = ST_B_GF_MUL;
            ST_B_GF_MUL:   state_next = ST_B_GF;
            ST_B_GF:       state_next = ST_B_L_MUL;
            ST_B_L_MUL:    state_next = ST_B_R_MUL;
            ST_B_R_MUL:    state_next = ST_B_R_ACC;
            ST_B_R_ACC:
                state_next = (band_reg == BAND_W'(BAND_COUNT - 1)) ? ST_M_DL : ST_B_MAG;
            ST_M_DL:       state_next = ST_M_AL;
            ST_M_AL:       state_next = ST_M_L;
            ST_M_L:        state_next = ST_M_AR;
            ST_M_AR:       state_next = ST_M_R;
            ST_M_R:        if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Memory port and multiplier operand control.
    always_comb
    begin
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_LP_RD:     mem_raddr = lp_addr;
            ST_LP_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(diff_reg);
                mul_b  = signed'({2'b00, xo_coef});
            end
            ST_LP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = lp_addr;
                mem_wdata = lp_y;
            end
            ST_B_MAG:     mem_raddr = env_addr;
            ST_B_ENV_LD:  mem_raddr = flr_addr;
            ST_B_FLR_LD:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({4'b0000, env_old_reg});
                mul_b  = signed'({2'b00, env_coef});
            end
            ST_B_ENV_M2:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({4'b0000, mag_reg});
                mul_b  = signed'({1'b0, env_coef_inv});
            end
            ST_B_ENV_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = env_addr;
                mem_wdata = smooth_new;
                mul_en    = 1'b1;
                mul_a     = signed'({4'b0000, flr_old_reg});
                mul_b     = signed'({2'b00, learn_coef_reg});
            end
            ST_B_FLR_M2:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({4'b0000, mag_reg});
                mul_b  = signed'({1'b0, learn_inv});
            end
            ST_B_FLR_WR:
            begin
                mem_we    = upd_reg;
                mem_waddr = flr_addr;
                mem_wdata = smooth_new;
            end
            ST_B_THR_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({4'b0000, flr_reg});
                mul_b  = signed'({3'b000, floor_scale_reg});
            end
            ST_B_SQ:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({20'd0, quo_reg});
                mul_b  = signed'({2'b00, quo_reg});
            end
            ST_B_GF_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = signed'({19'd0, gate_reg});
                mul_b  = signed'({1'b0, gf_inv});
            end
            ST_B_L_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(band_l_reg[band_reg]);
                mul_b  = signed'({1'b0, gate_reg});
            end
            ST_B_R_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(band_r_reg[band_reg]);
                mul_b  = signed'({1'b0, gate_reg});
            end
            ST_M_DL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(dry_l_reg);
                mul_b  = signed'({1'b0, mix_inv});
            end
            ST_M_AL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(acc_l_reg);
                mul_b  = signed'({1'b0, mix_cap});
            end
            ST_M_L:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(dry_r_reg);
                mul_b  = signed'({1'b0, mix_inv});
            end
            ST_M_AR:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(acc_r_reg);
                mul_b  = signed'({1'b0, mix_cap});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            xo_reg        <= '0;
            sec_reg       <= 1'b0;
            band_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    ch_reg   <= 1'b0;
                    xo_reg   <= '0;
                    sec_reg  <= 1'b0;
                    band_reg <= '0;
                end
                ST_LP_WR:
                begin
                    sec_reg <= !sec_reg;
                    if (sec_reg && (xo_reg != 2'(XOVER_COUNT - 1)))
                        xo_reg <= xo_reg + 2'd1;
                end
                ST_LP_B3:
                begin
                    ch_reg <= 1'b1;
                    xo_reg <= '0;
                end
                ST_B_GATE_CHK: cnt_reg  <= '0;
                ST_B_DIV:      cnt_reg  <= cnt_reg + 4'd1;
                ST_B_R_ACC:    band_reg <= band_reg + BAND_W'(1);
                default:       cnt_reg  <= cnt_reg;
            endcase
            // Output flag: a new result takes priority over the hand-off.
            if ((state_reg == ST_M_R) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    dry_l_reg <= STATE_BITS'(left_in) <<< FRAC_BITS;
                    dry_r_reg <= STATE_BITS'(right_in) <<< FRAC_BITS;
                    rest_reg  <= STATE_BITS'(left_in) <<< FRAC_BITS;
                end
                acc_l_reg <= '0;
                acc_r_reg <= '0;
            end
            ST_LP_RD:
            begin
                if (sec_reg)
                    hp_reg <= sat32(36'(rest_reg) - 36'(lp_reg));
            end
            ST_LP_DIFF:
            begin
                s_reg    <= signed'(rdata);
                diff_reg <= 33'(lp_src) - 33'(signed'(rdata));
            end
            ST_LP_WR:
            begin
                if (!sec_reg)
                    lp_reg <= lp_y;
                else
                begin
                    if (ch_reg)
                        band_r_reg[xo_reg] <= lp_y;
                    else
                        band_l_reg[xo_reg] <= lp_y;
                    if (xo_reg != 2'(XOVER_COUNT - 1))
                        rest_reg <= hp_reg;
                end
            end
            ST_LP_B3:
            begin
                if (ch_reg)
                    band_r_reg[BAND_COUNT-1] <= band3_val;
                else
                    band_l_reg[BAND_COUNT-1] <= band3_val;
                rest_reg <= dry_r_reg;
            end
            ST_B_MAG:      mag_reg     <= abs_sum[32:1];
            ST_B_ENV_LD:   env_old_reg <= rdata;
            ST_B_FLR_LD:   flr_old_reg <= rdata;
            ST_B_ENV_M2:
            begin
                sum_reg <= mul_reg;
                upd_reg <= learn_en_reg || (mag_x2 < flr_x3);
            end
            ST_B_ENV_WR:   env_reg <= smooth_new;
            ST_B_FLR_M2:   sum_reg <= mul_reg;
            ST_B_FLR_WR:   flr_reg <= upd_reg ? smooth_new : flr_old_reg;
            ST_B_THR:      thr_reg <= (thr_raw < 35'(LEVEL_EPS)) ? 35'(LEVEL_EPS) : thr_raw;
            ST_B_GATE_CHK:
            begin
                gate_reg <= COEF_ONE;
                rem_reg  <= {4'h0, env_reg};
                quo_reg  <= '0;
            end
            // Restoring division, one quotient bit per cycle.
            ST_B_DIV:
            begin
                rem_reg <= rem_ge ? (rem_x2 - {1'b0, thr_reg}) : rem_x2;
                quo_reg <= {quo_reg[COEF_BITS-2:0], rem_ge};
            end
            ST_B_SQ_WR:    gate_reg <= {1'b0, mul_reg[31:16]};
            ST_B_GF:       gate_reg <= gf_cap + mul_reg[32:16];
            ST_B_R_MUL:    acc_l_reg <= acc_l_reg + gated_term;
            ST_B_R_ACC:    acc_r_reg <= acc_r_reg + gated_term;
            ST_M_AL:       sum_reg   <= mul_reg;
            ST_M_L:        res_l_reg <= mix_out;
            ST_M_AR:       sum_reg   <= mul_reg;
            ST_M_R:
            begin
                if (out_free)
                begin
                    left_out_reg  <= res_l_reg;
                    right_out_reg <= mix_out;
                end
            end
            ST_M_DL:       sum_reg <= sum_reg;
            default:       sum_reg <= sum_reg;
        endcase
    end

endmodule

/* design/mang_chk.sv */
// Port-level checker for the multiband noise gate core, bound to the core module.
// Depends on mang_pkg for the sample width.
module mang_chk (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic signed [mang_pkg::SAMPLE_BITS-1:0] left_in,
    input logic signed [mang_pkg::SAMPLE_BITS-1:0] right_in,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic signed [mang_pkg::SAMPLE_BITS-1:0] left_out,
    input logic signed [mang_pkg::SAMPLE_BITS-1:0] right_out
);
    import mang_pkg::*;

    // A waiting result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("output word changed while stalled");

    // A result word leaves only when it is taken.
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("output word dropped");

    // After taking a word the core is busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    // No result appears just after acceptance.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind multiband_adaptive_noise_gate_core mang_chk u_mang_chk (.*);

/* bench/tb_top.sv */
// Self-checking bench for the four-band adaptive noise gate core.
// Directed words, then configuration phases of random words, each checked against
// given values or a predictor kept in step with the core. Depends on mang_pkg.
`timescale 1ns / 100ps

module tb_top;
    import mang_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int PHASES         = 12;
    localparam int WORDS_PER_PHASE = 90;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left_s;
        logic signed [SAMPLE_BITS-1:0] right_s;
        bit                            typed;
        logic signed [SAMPLE_BITS-1:0] left_x;
        logic signed [SAMPLE_BITS-1:0] right_x;
    } stim_row_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left_x;
        logic signed [SAMPLE_BITS-1:0] right_x;
    } stereo_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          cfg_write;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_W-1:0]              cfg_data;

    // Predictor copy of the configuration and the filter, envelope and floor state.
    logic [47:0] xover_q;
    longint      attack_q, release_q, learnc_q, scale_q, gfloor_q, wet_q;
    bit          learn_en_q;
    longint      lp_st [12];
    longint      env_st [4];
    longint      floor_st [4];

    stereo_t   gated_q [$];
    stim_row_t typed_q [$];
    int        fail_count;
    int        words_sent;
    int        results_seen;
    int        stall_count;
    bit        no_idle;

    multiband_adaptive_noise_gate_core dut (.*);

    always #1 clk = ~clk;

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 26);
    end

    function automatic longint sat_state(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint limit_one(input longint v);
        return (v > 65536) ? 65536 : v;
    endfunction

    // One-pole lowpass section; updates its stored state.
    function automatic longint lowpass_step(input int idx, input longint c, input longint x);
        longint y;
        y = sat_state(lp_st[idx] + ((c * (x - lp_st[idx])) >>> COEF_BITS));
        lp_st[idx] = y;
        return y;
    endfunction

    function automatic longint smooth_level(input longint prev, input longint c,
                                            input longint level);
        longint v;
        v = (c * prev + (65536 - c) * level) >>> COEF_BITS;
        return (v > 64'sd4294967295) ? 64'sd4294967295 : v;
    endfunction

    // Works out the gated stereo word for one input word and advances the state.
    function automatic stereo_t gate_word(input longint left_v, input longint right_v);
        longint  dry [2];
        longint  band [2][4];
        longint  acc [2];
        longint  rest, c, lp, hp, mag, env, thr, gain, ratio, gf, mix, v, l, r;
        stereo_t res;
        gf  = limit_one(gfloor_q);
        mix = limit_one(wet_q);
        for (int ch = 0; ch < 2; ch++)
        begin
            rest = (ch == 0 ? left_v : right_v) * 256;
            dry[ch] = rest;
            acc[ch] = 0;
            for (int x = 0; x < 3; x++)
            begin
                c  = limit_one(longint'(xover_q[16*x +: 16]));
                lp = lowpass_step(ch * 6 + x * 2, c, rest);
                hp = sat_state(rest - lp);
                band[ch][x] = lowpass_step(ch * 6 + x * 2 + 1, c, lp);
                if (x == 2)
                    band[ch][3] = sat_state(rest - band[ch][x]);
                rest = hp;
            end
        end
        for (int b = 0; b < 4; b++)
        begin
            l   = band[0][b];
            r   = band[1][b];
            mag = ((l < 0 ? -l : l) + (r < 0 ? -r : r)) >>> 1;
            env_st[b] = smooth_level(env_st[b], mag > env_st[b] ?
                                     limit_one(attack_q) : limit_one(release_q), mag);
            if (learn_en_q || mag * 2 < floor_st[b] * 3)
                floor_st[b] = smooth_level(floor_st[b], limit_one(learnc_q), mag);
            env = env_st[b];
            thr = (floor_st[b] * scale_q) >>> SCALE_BITS;
            if (thr < 2147)
                thr = 2147;
            if (env <= 2147 || env >= thr)
                gain = 65536;
            else
            begin
                ratio = (env <<< COEF_BITS) / thr;
                gain  = (ratio * ratio) >>> COEF_BITS;
            end
            gain = gf + (((65536 - gf) * gain) >>> COEF_BITS);
            acc[0] += (l * gain) >>> COEF_BITS;
            acc[1] += (r * gain) >>> COEF_BITS;
        end
        for (int ch = 0; ch < 2; ch++)
        begin
            v = (dry[ch] * (65536 - mix) + acc[ch] * mix) >>> COEF_BITS;
            v = v >>> FRAC_BITS;
            if (v > 8388607)
                v = 8388607;
            if (v < -8388608)
                v = -8388608;
            if (ch == 0)
                res.left_x = v[SAMPLE_BITS-1:0];
            else
                res.right_x = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    // Input monitor: predicts each accepted word.
    always @(posedge clk)
    begin
        stim_row_t row;
        stereo_t   pred;
        if (rst_n && in_valid && in_ready)
        begin
            row  = typed_q.pop_front();
            pred = gate_word(longint'(left_in), longint'(right_in));
            if (row.typed)
            begin
                pred.left_x  = row.left_x;
                pred.right_x = row.right_x;
            end
            gated_q.push_back(pred);
        end
    end

    // Output monitor: compares each result word with the oldest prediction.
    always @(posedge clk)
    begin
        stereo_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (gated_q.size() == 0)
            begin
                $display("%0t: result word with nothing pending: %0d %0d",
                         $time, left_out, right_out);
                fail_count++;
            end
            else
            begin
                want = gated_q.pop_front();
                if (left_out !== want.left_x)
                begin
                    $display("%0t: left_out expected %0d actual %0d",
                             $time, want.left_x, left_out);
                    fail_count++;
                end
                if (right_out !== want.right_x)
                begin
                    $display("%0t: right_out expected %0d actual %0d",
                             $time, want.right_x, right_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count > WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress, giving up", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Writes all eight registers on consecutive cycles while the core is idle.
    task automatic write_settings(input logic [47:0] xo, input int atk, input int rel,
                                  input int lrn, input int scl, input int gfl,
                                  input int wet, input bit len);
        logic [CFG_W-1:0] vals [8];
        vals[REG_XOVER_COEFS] = xo;
        vals[REG_ATTACK]      = CFG_W'(atk);
        vals[REG_RELEASE]     = CFG_W'(rel);
        vals[REG_LEARN_COEF]  = CFG_W'(lrn);
        vals[REG_FLOOR_SCALE] = CFG_W'(scl);
        vals[REG_GATE_FLOOR]  = CFG_W'(gfl);
        vals[REG_WET_MIX]     = CFG_W'(wet);
        vals[REG_LEARN_EN]    = CFG_W'(len);
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write  <= 1'b0;
        xover_q    = xo;
        attack_q   = atk & 16'hFFFF;
        release_q  = rel & 16'hFFFF;
        learnc_q   = lrn & 16'hFFFF;
        scale_q    = scl & 15'h7FFF;
        gfloor_q   = gfl & 17'h1FFFF;
        wet_q      = wet & 17'h1FFFF;
        learn_en_q = len;
    endtask

    // Offers one word, with an optional gap before it, and waits for acceptance.
    task automatic send_word(input stim_row_t row);
        int gap;
        gap = (!no_idle && $urandom_range(0, 99) < 26) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        typed_q.push_back(row);
        in_valid <= 1'b1;
        left_in  <= row.left_s;
        right_in <= row.right_s;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    task automatic drain_core();
        in_valid <= 1'b0;
        while (gated_q.size() != 0 || typed_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Random sample: full range, or noise at a random or the given level with random sign.
    function automatic logic signed [SAMPLE_BITS-1:0] noise_sample(input int lvl);
        int mode;
        logic [SAMPLE_BITS-1:0] v;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            return SAMPLE_BITS'($urandom);
        if (mode == 1)
            lvl = $urandom_range(0, 22);
        v = SAMPLE_BITS'($urandom) & ((24'd1 << lvl) - 24'd1);
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    stim_row_t directed [];

    initial
    begin
        stim_row_t row;
        int        lvl;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        left_in    = '0;
        right_in   = '0;
        out_ready  = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        no_idle    = 1'b0;
        fail_count = 0;
        words_sent = 0;
        results_seen = 0;
        stall_count  = 0;
        xover_q = 48'd0; attack_q = 65000; release_q = 65400; learnc_q = 65534;
        scale_q = 12288; gfloor_q = 13107; wet_q = 65536; learn_en_q = 1'b0;
        foreach (lp_st[i]) lp_st[i] = 0;
        foreach (env_st[i]) begin env_st[i] = 0; floor_st[i] = 0; end

        // Directed words under the reset settings: silence passes as zero, and
        // the loud words after it pass unchanged since the floor is still zero.
        directed = '{
            '{24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0},
            '{24'sd8388607, -24'sd8388608, 1'b1, 24'sd8388607, -24'sd8388608},
            '{-24'sd8388608, 24'sd8388607, 1'b1, -24'sd8388608, 24'sd8388607},
            '{24'sd1, -24'sd1, 1'b0, 24'sd0, 24'sd0},
            '{-24'sd1, 24'sd1, 1'b0, 24'sd0, 24'sd0},
            '{24'sh555555, 24'shAAAAAA, 1'b0, 24'sd0, 24'sd0},
            '{24'shAAAAAA, 24'sh555555, 1'b0, 24'sd0, 24'sd0},
            '{24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0},
            '{24'sd3, 24'sd2, 1'b0, 24'sd0, 24'sd0},
            '{24'sd100, -24'sd100, 1'b0, 24'sd0, 24'sd0},
            '{24'sd8388607, 24'sd8388607, 1'b0, 24'sd0, 24'sd0},
            '{-24'sd8388608, -24'sd8388608, 1'b0, 24'sd0, 24'sd0},
            '{24'sd5, 24'sd0, 1'b0, 24'sd0, 24'sd0},
            '{24'sd0, -24'sd7, 1'b0, 24'sd0, 24'sd0},
            '{24'sd4096, 24'sd4096, 1'b0, 24'sd0, 24'sd0},
            '{24'sd65535, -24'sd65536, 1'b0, 24'sd0, 24'sd0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_word(directed[i]);

        // Phases of random words, each under its own settings.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_core();
            no_idle = (ph == 3);
            case (ph)
                0: write_settings(48'h0, 0, 0, 0, 4096, 0, 65536, 1'b1);
                1: write_settings(48'hFFFF_FFFF_FFFF, 65535, 65535, 65535, 20480,
                                  65536, 65536, 1'b0);
                2: write_settings(48'h4000_2000_1000, 60000, 65000, 60000, 12288,
                                  131071, 131071, 1'b1);
                3: write_settings(48'h4000_2000_1000, 30000, 65500, 65000, 20480,
                                  0, 65536, 1'b0);
                4: write_settings(48'h8000_6000_0800, 65000, 65400, 65534, 8192,
                                  13107, 0, 1'b0);
                default:
                    write_settings(CFG_W'({$urandom, $urandom}), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(4096, 20480), $urandom_range(0, 131071),
                                   $urandom_range(0, 131071), $urandom_range(0, 1));
            endcase
            lvl = $urandom_range(2, 20);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // Mostly steady noise, with loud bursts so the gate opens and closes.
                if ($urandom_range(0, 29) == 0)
                    lvl = $urandom_range(2, 22);
                row.left_s  = noise_sample(lvl);
                row.right_s = noise_sample(lvl);
                row.typed   = 1'b0;
                row.left_x  = '0;
                row.right_x = '0;
                send_word(row);
            end
        end
        drain_core();

        $display("Sent %0d stereo words over %0d settings phases; %0d results checked.",
                 words_sent, PHASES + 1, results_seen);
        $display("Covered extremes, oversized gains, learning on and off, gating noise.");
        if (fail_count == 0 && gated_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
